[rtl/clcd_pkg.sv]
// Shared types and constants for the character display cursor controller.
// No dependencies; imported by clcd_ctrl, clcd_dp and char_lcd_cursor_controller.
package clcd_pkg;

  // Default number of columns per display row
  localparam int unsigned COLUMNS_DEF = 16;

  // Operation codes
  localparam logic [3:0] OP_WRITE_CHAR = 4'd0;
  localparam logic [3:0] OP_CLEAR      = 4'd1;
  localparam logic [3:0] OP_CLEAR_EOL  = 4'd2;
  localparam logic [3:0] OP_UP         = 4'd3;
  localparam logic [3:0] OP_DOWN       = 4'd4;
  localparam logic [3:0] OP_RIGHT      = 4'd5;
  localparam logic [3:0] OP_LEFT       = 4'd6;
  localparam logic [3:0] OP_SET        = 4'd7;
  localparam logic [3:0] OP_GET        = 4'd8;

  // Write kinds on the result channel
  localparam logic [1:0] KIND_IR     = 2'd0;
  localparam logic [1:0] KIND_DR     = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Display bytes
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_PRINT_HI = 8'h7F;
  localparam logic [7:0] INSTR_CLEAR   = 8'h01;
  localparam logic [7:0] INSTR_SET_ROW0 = 8'h80;
  localparam logic [7:0] INSTR_ROW1_OFS = 8'h40;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;   // latch accepted item, update cursor
    logic emit_data;   // load a data-register write into the output stage
    logic emit_final;  // load the closing result into the output stage
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic data_pending; // data writes still to send for this item
  } dp_sts_t;

endpackage

[rtl/char_lcd_cursor_controller.sv]
// Two-row character display cursor controller; one operation in, 1..COLUMNS+1 writes out.
// The operation's plan is registered at the input transfer; its first result is then loaded into the output stage.
// The single output stage sends one write per cycle while out_ready_i is high; a new
//   operation is taken only after the previous one has loaded its closing result.
// Reset (rst_ni low, asynchronous): cursor to top left, controller idle, no result valid.
// Depends on clcd_pkg, clcd_ctrl, clcd_dp.
module char_lcd_cursor_controller #(
  parameter int unsigned COLUMNS = clcd_pkg::COLUMNS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // operation channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] operation_i,
  input  logic [7:0] char_code_i,
  input  logic       row_i,
  input  logic [3:0] column_i,
  // write channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] write_kind_o,
  output logic [7:0] bus_byte_o,
  output logic       ok_o,
  output logic       cursor_row_o,
  output logic [3:0] cursor_column_o,
  output logic       last_o
);
  import clcd_pkg::*;

  // The controller takes one operation at a time. At the input transfer the
  // datapath works out the new cursor, how many data writes precede the closing
  // result (one for a printable character, one space per cell to the row end
  // for clear-to-end-of-line) and the closing result itself: a set-address
  // instruction, the clear instruction or a status-only answer. Every result
  // reports the cursor as it stands after the whole operation.
  // A fresh operation is taken while the last write of the previous one still
  // waits in the output stage.

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  clcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  clcd_dp #(
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .char_code_i     (char_code_i),
    .row_i           (row_i),
    .column_i        (column_i),
    .write_kind_o    (write_kind_o),
    .bus_byte_o      (bus_byte_o),
    .ok_o            (ok_o),
    .cursor_row_o    (cursor_row_o),
    .cursor_column_o (cursor_column_o),
    .last_o          (last_o)
  );

endmodule

[rtl/clcd_dp.sv]
// Datapath: cursor registers, per-item result plan and output stage.
// Depends on clcd_pkg.
module clcd_dp #(
  parameter int unsigned COLUMNS = clcd_pkg::COLUMNS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  clcd_pkg::ctrl_cmd_t cmd_i,
  output clcd_pkg::dp_sts_t sts_o,
  input  logic [3:0]        operation_i,
  input  logic [7:0]        char_code_i,
  input  logic              row_i,
  input  logic [3:0]        column_i,
  output logic [1:0]        write_kind_o,
  output logic [7:0]        bus_byte_o,
  output logic              ok_o,
  output logic              cursor_row_o,
  output logic [3:0]        cursor_column_o,
  output logic              last_o
);
  import clcd_pkg::*;

  localparam int unsigned CW   = $clog2(COLUMNS);
  localparam int unsigned CNTW = $clog2(COLUMNS + 1);
  localparam int unsigned CMPW = (CNTW > 4) ? CNTW : 4;
  localparam logic [CW-1:0] LastCol = CW'(COLUMNS - 1);

  logic            row_q, row_d;
  logic [CW-1:0]   col_q, col_d;
  logic [CNTW-1:0] cnt_q, cnt_d, n_cnt;
  logic [7:0]      data_byte_q;
  logic [1:0]      fin_kind_q, n_kind;
  logic [7:0]      fin_byte_q, n_byte;
  logic            fin_ok_q, n_ok;
  logic            n_row, adv_row;
  logic [CW-1:0]   n_col, adv_col;
  logic            printable, n_addr;

  logic [1:0]      kind_q;
  logic [7:0]      byte_q;
  logic            ok_q, orow_q, last_q;
  logic [CW-1:0]   ocol_q;

  assign printable = (char_code_i >= CHAR_SPACE) && (char_code_i <= CHAR_PRINT_HI);

  // one cell forward, wrapping row end to next row and bottom right to top left
  always_comb begin
    if (col_q == LastCol) begin
      adv_col = '0;
      adv_row = ~row_q;
    end else begin
      adv_col = col_q + CW'(1);
      adv_row = row_q;
    end
  end

  // plan: new cursor, number of data writes, closing result
  always_comb begin
    n_row  = row_q;
    n_col  = col_q;
    n_cnt  = '0;
    n_ok   = 1'b0;
    n_addr = 1'b0;
    n_kind = KIND_STATUS;
    unique case (operation_i)
      OP_WRITE_CHAR: begin
        if (printable) begin
          n_row  = adv_row;
          n_col  = adv_col;
          n_cnt  = CNTW'(1);
          n_addr = 1'b1;
        end
      end
      OP_CLEAR: begin
        n_row  = 1'b0;
        n_col  = '0;
        n_kind = KIND_IR;
        n_ok   = 1'b1;
      end
      OP_CLEAR_EOL: begin
        n_cnt  = CNTW'(COLUMNS) - CNTW'(col_q);
        n_addr = 1'b1;
      end
      OP_UP: begin
        if (row_q) begin
          n_row  = 1'b0;
          n_addr = 1'b1;
        end
      end
      OP_DOWN: begin
        if (!row_q) begin
          n_row  = 1'b1;
          n_addr = 1'b1;
        end
      end
      OP_RIGHT: begin
        if (!(row_q && (col_q == LastCol))) begin
          n_row  = adv_row;
          n_col  = adv_col;
          n_addr = 1'b1;
        end
      end
      OP_LEFT: begin
        if (row_q || (col_q != '0)) begin
          if (col_q == '0) begin
            n_col = LastCol;
            n_row = 1'b0;
          end else begin
            n_col = col_q - CW'(1);
          end
          n_addr = 1'b1;
        end
      end
      OP_SET: begin
        if (CMPW'(column_i) < CMPW'(COLUMNS)) begin
          n_row  = row_i;
          n_col  = CW'(column_i);
          n_addr = 1'b1;
        end
      end
      OP_GET: n_ok = 1'b1;
      default: n_ok = 1'b0;
    endcase
    if (n_addr) begin
      n_kind = KIND_IR;
      n_ok   = 1'b1;
    end
  end

  always_comb begin
    if (n_addr) begin
      n_byte = INSTR_SET_ROW0 | (n_row ? INSTR_ROW1_OFS : 8'h00) | 8'(n_col);
    end else if (n_kind == KIND_IR) begin
      n_byte = INSTR_CLEAR;
    end else begin
      n_byte = 8'h00;
    end
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    cnt_d = cnt_q;
    if (cmd_i.load_item) begin
      row_d = n_row;
      col_d = n_col;
      cnt_d = n_cnt;
    end else if (cmd_i.emit_data) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= 1'b0;
      col_q <= '0;
      cnt_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      data_byte_q <= (operation_i == OP_WRITE_CHAR) ? char_code_i : CHAR_SPACE;
      fin_kind_q  <= n_kind;
      fin_byte_q  <= n_byte;
      fin_ok_q    <= n_ok;
    end
  end

  // output stage; cursor is already final when the item's results go out
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_data) begin
      kind_q <= KIND_DR;
      byte_q <= data_byte_q;
      ok_q   <= 1'b1;
      last_q <= 1'b0;
      orow_q <= row_q;
      ocol_q <= col_q;
    end else if (cmd_i.emit_final) begin
      kind_q <= fin_kind_q;
      byte_q <= fin_byte_q;
      ok_q   <= fin_ok_q;
      last_q <= 1'b1;
      orow_q <= row_q;
      ocol_q <= col_q;
    end
  end

  assign sts_o.data_pending = (cnt_q != '0);
  assign write_kind_o    = kind_q;
  assign bus_byte_o      = byte_q;
  assign ok_o            = ok_q;
  assign cursor_row_o    = orow_q;
  assign cursor_column_o = 4'(ocol_q);
  assign last_o          = last_q;

  // column register never leaves the row
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= LastCol) else $error("cursor column out of range");

  // pending data writes never exceed one row
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(COLUMNS)) else $error("data write count out of range");

  // data writes never move the cursor
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_data |=> (row_q == $past(row_q)) && (col_q == $past(col_q)))
    else $error("cursor moved during data writes");

endmodule

[rtl/clcd_ctrl.sv]
// Controller: input handshake, result sequencing and output valid.
// Depends on clcd_pkg.
module clcd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output clcd_pkg::ctrl_cmd_t cmd_o,
  input  clcd_pkg::dp_sts_t   sts_i
);
  import clcd_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d          = state_q;
    cmd_o.load_item  = 1'b0;
    cmd_o.emit_data  = 1'b0;
    cmd_o.emit_final = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_free) begin
          if (sts_i.data_pending) begin
            cmd_o.emit_data = 1'b1;
          end else begin
            cmd_o.emit_final = 1'b1;
            state_d          = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.emit_data || cmd_o.emit_final) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // output stage is only reloaded once its transfer is done or it is empty
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_data || cmd_o.emit_final) |-> out_free)
    else $error("output stage overwritten");

  // a data write is only issued while writes remain
  a_data_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_data |-> sts_i.data_pending) else $error("spurious data write");

  // closing result returns the controller to idle
  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_final |=> (state_q == ST_IDLE) && out_valid_o)
    else $error("closing result not followed by idle");

endmodule
